### rtl/sjis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_pkg
// Shared types, constants and byte classification functions for the
// Shift-JIS string checker.
// ----------------------------------------------------------------------------
package sjis_pkg;

    // Width of the internal byte and character tallies.
    localparam int COUNT_BITS = 16;
    // Width of the reported counts.
    localparam int OUT_BITS   = 16;
    // Working width for the reported counts: a tally plus one, at least OUT_BITS + 1.
    localparam int CALC_BITS  = (COUNT_BITS + 1 > OUT_BITS + 1) ? COUNT_BITS + 1 : OUT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] TALLY_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CALC_BITS-1:0]  OUT_MAX   = CALC_BITS'({OUT_BITS{1'b1}});

    // Packed result width, rounded up to whole bytes.
    localparam int RESULT_BITS = 1 + 2 * OUT_BITS;
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    // Byte codes.
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] ASCII_LO       = 8'h20;
    localparam logic [7:0] ASCII_HI       = 8'h7F;
    localparam logic [7:0] KANA_LO        = 8'hA1;
    localparam logic [7:0] KANA_HI        = 8'hDF;
    localparam logic [7:0] LEAD1_LO       = 8'h81;
    localparam logic [7:0] LEAD1_HI       = 8'h9F;
    localparam logic [7:0] LEAD2_LO       = 8'hE0;
    localparam logic [7:0] LEAD2_HI       = 8'hEF;
    localparam logic [7:0] TRAIL_LO       = 8'h40;
    localparam logic [7:0] TRAIL_GAP      = 8'h7F;
    localparam logic [7:0] TRAIL_LIMIT    = 8'hFD;

    // Unassigned or unsupported double-byte code ranges, inclusive.
    localparam int BAD_RANGES = 23;
    localparam logic [15:0] BAD_LO [BAD_RANGES] = '{
        16'h81AD, 16'h81C0, 16'h81CF, 16'h81E9, 16'h81F8, 16'h8240, 16'h8259,
        16'h827A, 16'h829B, 16'h82F2, 16'h8397, 16'h83B7, 16'h83D7, 16'h8461,
        16'h8492, 16'h84BF, 16'h875E, 16'h8776, 16'h879D, 16'h9873, 16'hA040,
        16'hEAA5, 16'hEEED
    };
    localparam logic [15:0] BAD_HI [BAD_RANGES] = '{
        16'h81B7, 16'h81C7, 16'h81D9, 16'h81EF, 16'h81FB, 16'h824E, 16'h825F,
        16'h8280, 16'h829E, 16'h82FC, 16'h839E, 16'h83BE, 16'h83FC, 16'h846F,
        16'h849E, 16'h889E, 16'h875E, 16'h877D, 16'h889E, 16'h989E, 16'hE03F,
        16'hFFFF, 16'hEEEE
    };

    // One buffer byte as it travels from the input register.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } sjis_item_t;

    // Classification of the current byte.
    typedef struct packed {
        logic is_nul;
        logic is_lead;
        logic is_single;
        logic pair_ok;
    } sjis_class_t;

    function automatic logic is_lead_byte(input logic [7:0] b);
        return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI));
    endfunction

    function automatic logic is_single_byte(input logic [7:0] b);
        return (b == BYTE_LF) || (b == BYTE_CR) || ((b >= ASCII_LO) && (b <= ASCII_HI)) ||
               ((b >= KANA_LO) && (b <= KANA_HI));
    endfunction

    // A lead/trail pair is valid when the trail is in range and the code
    // falls in none of the excluded ranges.
    function automatic logic pair_valid(input logic [7:0] lead, input logic [7:0] trail);
        logic [15:0] code;
        logic        hit;
        code = {lead, trail};
        hit  = 1'b0;
        for (int i = 0; i < BAD_RANGES; i++)
        begin
            if ((code >= BAD_LO[i]) && (code <= BAD_HI[i]))
            begin
                hit = 1'b1;
            end
        end
        return !hit && (trail >= TRAIL_LO) && (trail != TRAIL_GAP) && (trail < TRAIL_LIMIT);
    endfunction

endpackage
`default_nettype wire

### rtl/sjis_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_in_stage
// Input register: captures one byte transfer and holds it until the scan
// stage takes it.
// ----------------------------------------------------------------------------
module sjis_in_stage
    import sjis_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_buffer
    output logic            item_valid,
    output sjis_item_t      item,
    input  wire logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    sjis_item_t item_reg;

    // The register is free when empty or when its byte leaves this cycle.
    assign s_tready   = !valid_reg || item_take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

### rtl/sjis_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_classify
// Combinational byte classifier: terminator, lead byte, single-byte
// character, and validity of the pair formed with a pending lead byte.
// ----------------------------------------------------------------------------
module sjis_classify
    import sjis_pkg::*;
(
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] lead_value,
    output sjis_class_t     byte_class
);

    // All tests run in parallel on the current byte.
    always_comb
    begin
        byte_class.is_nul    = (data_byte == BYTE_NUL);
        byte_class.is_lead   = is_lead_byte(data_byte);
        byte_class.is_single = is_single_byte(data_byte);
        byte_class.pair_ok   = pair_valid(lead_value, data_byte);
    end

endmodule
`default_nettype wire

### rtl/sjis_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_scan
// Scan state and result register: updates the tallies for each byte and
// loads one result per buffer into the output register.
// ----------------------------------------------------------------------------
module sjis_scan
    import sjis_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire sjis_item_t            item,
    output logic                       item_take,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_BITS-1:0]      m_tdata
);

    logic                  lead_pending_reg, lead_pending_next;
    logic [7:0]            lead_value_reg, lead_value_next;
    logic [COUNT_BITS-1:0] byte_tally_reg, byte_tally_next;
    logic [COUNT_BITS-1:0] char_tally_reg, char_tally_next;
    logic                  skipping_reg, skipping_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  ok_reg, ok_next;
    logic [OUT_BITS-1:0]   raw_length_reg, raw_length_next;
    logic [OUT_BITS-1:0]   char_total_reg, char_total_next;

    sjis_class_t           byte_class;
    logic                  produce;
    logic                  good;
    logic                  fire;
    logic [COUNT_BITS:0]   byte_plus1, byte_plus2, char_plus1;
    logic [CALC_BITS-1:0]  len_wide, chars_wide;

    sjis_classify u_classify (
        .data_byte  (item.data),
        .lead_value (lead_value_reg),
        .byte_class (byte_class)
    );

    // Saturating tally increments.
    assign byte_plus1 = {1'b0, byte_tally_reg} + (COUNT_BITS+1)'(1);
    assign byte_plus2 = {1'b0, byte_tally_reg} + (COUNT_BITS+1)'(2);
    assign char_plus1 = {1'b0, char_tally_reg} + (COUNT_BITS+1)'(1);

    // Reported counts, saturated to the output width.
    assign len_wide   = CALC_BITS'(byte_tally_reg) + CALC_BITS'(1);
    assign chars_wide = CALC_BITS'(char_tally_reg);

    // Decide whether this byte ends the string and whether the string is good.
    always_comb
    begin
        produce = 1'b0;
        good    = 1'b0;
        if (skipping_reg)
        begin
            produce = 1'b0;
        end
        else if (lead_pending_reg)
        begin
            produce = !byte_class.pair_ok || item.last;
        end
        else if (byte_class.is_nul)
        begin
            produce = 1'b1;
            good    = (byte_tally_reg != '0);
        end
        else if (byte_class.is_lead)
        begin
            produce = item.last;
        end
        else
        begin
            produce = !byte_class.is_single || item.last;
        end
    end

    // A byte that yields no result never waits for the output side.
    assign fire      = item_valid && (!produce || !out_valid_reg || m_tready);
    assign item_take = fire;

    // Next state.
    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_value_next   = lead_value_reg;
        byte_tally_next   = byte_tally_reg;
        char_tally_next   = char_tally_reg;
        skipping_next     = skipping_reg;
        if (fire)
        begin
            if (skipping_reg)
            begin
                skipping_next = !item.last;
            end
            else if (produce)
            begin
                lead_pending_next = 1'b0;
                lead_value_next   = '0;
                byte_tally_next   = '0;
                char_tally_next   = '0;
                skipping_next     = !item.last;
            end
            else if (lead_pending_reg)
            begin
                lead_pending_next = 1'b0;
                lead_value_next   = '0;
                byte_tally_next   = byte_plus2[COUNT_BITS] ? TALLY_MAX
                                                           : byte_plus2[COUNT_BITS-1:0];
                char_tally_next   = char_plus1[COUNT_BITS] ? TALLY_MAX
                                                           : char_plus1[COUNT_BITS-1:0];
            end
            else if (byte_class.is_lead)
            begin
                lead_pending_next = 1'b1;
                lead_value_next   = item.data;
            end
            else
            begin
                byte_tally_next = byte_plus1[COUNT_BITS] ? TALLY_MAX
                                                         : byte_plus1[COUNT_BITS-1:0];
                char_tally_next = char_plus1[COUNT_BITS] ? TALLY_MAX
                                                         : char_plus1[COUNT_BITS-1:0];
            end
        end
    end

    // Result register contents.
    always_comb
    begin
        out_valid_next  = (out_valid_reg && !m_tready) || (fire && produce);
        ok_next         = ok_reg;
        raw_length_next = raw_length_reg;
        char_total_next = char_total_reg;
        if (fire && produce)
        begin
            ok_next         = good;
            raw_length_next = !good ? '0 :
                              (len_wide > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : len_wide[OUT_BITS-1:0];
            char_total_next = !good ? '0 :
                              (chars_wide > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0]
                                                     : chars_wide[OUT_BITS-1:0];
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_value_reg   <= '0;
            byte_tally_reg   <= '0;
            char_tally_reg   <= '0;
            skipping_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_value_reg   <= lead_value_next;
            byte_tally_reg   <= byte_tally_next;
            char_tally_reg   <= char_tally_next;
            skipping_reg     <= skipping_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        ok_reg         <= ok_next;
        raw_length_reg <= raw_length_next;
        char_total_reg <= char_total_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'({char_total_reg, raw_length_reg, ok_reg});

endmodule
`default_nettype wire

### rtl/shift_jis_string_checker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shift_jis_string_checker_top
// Checks that a byte buffer begins with a non-empty, null-terminated
// Shift-JIS string.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per cycle on the slave stream, with tlast
// on the final byte, and gives one result per buffer on the master stream:
// at the terminator, at the first invalid character, or at the final byte.
// Bytes after the result, up to tlast, are consumed without a result. Each
// byte passes through an input register and one stage of range compares and
// saturating counter updates, so the sustained rate is one byte per cycle and
// a result is loaded into the output register as its byte leaves the input
// register. The only wait comes from the result register: a byte that yields
// a result stalls while the previous result has not been taken.
module shift_jis_string_checker_top
    import sjis_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,   // end_of_buffer
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_BITS-1:0]      m_tdata    // [0] ok, [16:1] raw_length,
                                                  // [32:17] char_total, rest zero
);

    logic       item_valid;
    logic       item_take;
    sjis_item_t item;

    // Input register.
    sjis_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Scan state and result register.
    sjis_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

### tb/shift_jis_string_checker_checker.sv
// ----------------------------------------------------------------------------
// shift_jis_string_checker_checker
// Watches both streams of the Shift-JIS string checker. Every byte transfer
// runs through a local scan of the buffer that computes the expected verdict.
// Every result transfer is compared field by field against the oldest
// outstanding verdict.
// ----------------------------------------------------------------------------
module shift_jis_string_checker_checker
    import sjis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // end_of_buffer
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_BITS-1:0] m_tdata,   // [0] ok, [16:1] raw_length,
                                             // [32:17] char_total, rest zero
    output int                    mismatches,
    output int                    results_due
);

    // One verdict as the block should report it.
    typedef struct packed {
        logic                ok;
        logic [OUT_BITS-1:0] raw_length;
        logic [OUT_BITS-1:0] char_total;
    } verdict_t;

    localparam logic [COUNT_BITS-1:0] TALLY_TOP = '1;
    localparam longint unsigned       OUT_TOP   = (64'd1 << OUT_BITS) - 1;
    localparam int                    GAP_COUNT = 23;

    // Double-byte codes that are unassigned or unsupported, inclusive.
    localparam logic [15:0] GAP_FIRST [GAP_COUNT] = '{
        16'h81AD, 16'h81C0, 16'h81CF, 16'h81E9, 16'h81F8, 16'h8240, 16'h8259,
        16'h827A, 16'h829B, 16'h82F2, 16'h8397, 16'h83B7, 16'h83D7, 16'h8461,
        16'h8492, 16'h84BF, 16'h875E, 16'h8776, 16'h879D, 16'h9873, 16'hA040,
        16'hEAA5, 16'hEEED
    };
    localparam logic [15:0] GAP_LAST [GAP_COUNT] = '{
        16'h81B7, 16'h81C7, 16'h81D9, 16'h81EF, 16'h81FB, 16'h824E, 16'h825F,
        16'h8280, 16'h829E, 16'h82FC, 16'h839E, 16'h83BE, 16'h83FC, 16'h846F,
        16'h849E, 16'h889E, 16'h875E, 16'h877D, 16'h889E, 16'h989E, 16'hE03F,
        16'hFFFF, 16'hEEEE
    };

    verdict_t               verdict_q[$];
    logic                   awaiting_trail;
    logic [7:0]             held_lead;
    logic [COUNT_BITS-1:0]  valid_bytes;
    logic [COUNT_BITS-1:0]  valid_chars;
    logic                   draining;
    int                     error_total = 0;
    int                     result_index = 0;
    int                     pending_total = 0;

    assign mismatches  = error_total;
    assign results_due = pending_total;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_index, msg);
        error_total++;
    endtask

    function automatic logic is_lead_code(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
    endfunction

    function automatic logic stands_alone(input logic [7:0] b);
        return b == BYTE_LF || b == BYTE_CR || (b >= 8'h20 && b <= 8'h7F) ||
               (b >= 8'hA1 && b <= 8'hDF);
    endfunction

    // A pair passes when its trail is in range and its code misses every gap.
    function automatic logic double_byte_ok(input logic [7:0] lead, input logic [7:0] trail);
        logic [15:0] code;
        logic        good;
        code = {lead, trail};
        good = (trail >= 8'h40) && (trail != 8'h7F) && (trail <= 8'hFC);
        for (int i = 0; i < GAP_COUNT; i++)
        begin
            if (code >= GAP_FIRST[i] && code <= GAP_LAST[i])
            begin
                good = 1'b0;
            end
        end
        return good;
    endfunction

    // Saturating tally increment.
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v,
                                                   input int step);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, v} + (COUNT_BITS + 1)'(step);
        return sum[COUNT_BITS] ? TALLY_TOP : sum[COUNT_BITS-1:0];
    endfunction

    task automatic clear_scan();
        awaiting_trail = 1'b0;
        held_lead      = 8'h00;
        valid_bytes    = '0;
        valid_chars    = '0;
        draining       = 1'b0;
    endtask

    // Queues the verdict for the current buffer and starts over.
    task automatic close_string(input logic good, input logic eob);
        verdict_t       v;
        longint unsigned len;
        longint unsigned chars;
        len          = longint'(valid_bytes) + 1;
        chars        = longint'(valid_chars);
        v.ok         = good;
        v.raw_length = good ? OUT_BITS'(len > OUT_TOP ? OUT_TOP : len) : '0;
        v.char_total = good ? OUT_BITS'(chars > OUT_TOP ? OUT_TOP : chars) : '0;
        verdict_q.push_back(v);
        clear_scan();
        draining = !eob;
    endtask

    // Advances the scan by one buffer byte.
    task automatic scan_byte(input logic [7:0] b, input logic eob);
        if (draining)
        begin
            if (eob)
            begin
                clear_scan();
            end
        end
        else if (awaiting_trail)
        begin
            awaiting_trail = 1'b0;
            if (!double_byte_ok(held_lead, b))
            begin
                close_string(1'b0, eob);
            end
            else
            begin
                valid_bytes = bump(valid_bytes, 2);
                valid_chars = bump(valid_chars, 1);
                held_lead   = 8'h00;
                if (eob)
                begin
                    close_string(1'b0, eob);
                end
            end
        end
        else if (b == BYTE_NUL)
        begin
            close_string(valid_bytes != '0, eob);
        end
        else if (is_lead_code(b))
        begin
            if (eob)
            begin
                close_string(1'b0, eob);
            end
            else
            begin
                awaiting_trail = 1'b1;
                held_lead      = b;
            end
        end
        else if (!stands_alone(b))
        begin
            close_string(1'b0, eob);
        end
        else
        begin
            valid_bytes = bump(valid_bytes, 1);
            valid_chars = bump(valid_chars, 1);
            if (eob)
            begin
                close_string(1'b0, eob);
            end
        end
    endtask

    // Compares one result transfer with the oldest outstanding verdict.
    task automatic check_result(input logic [TDATA_BITS-1:0] data);
        verdict_t            want;
        logic                got_ok;
        logic [OUT_BITS-1:0] got_len;
        logic [OUT_BITS-1:0] got_chars;
        logic [TDATA_BITS-1:0] got_pad;
        got_ok    = data[0];
        got_len   = data[OUT_BITS:1];
        got_chars = data[2*OUT_BITS:OUT_BITS+1];
        got_pad   = data >> RESULT_BITS;
        if (verdict_q.size() == 0)
        begin
            report_mismatch($sformatf("result 0x%0h with none expected", data));
        end
        else
        begin
            want = verdict_q.pop_front();
            if (got_ok !== want.ok)
            begin
                report_mismatch($sformatf("ok got %0b want %0b", got_ok, want.ok));
            end
            if (got_len !== want.raw_length)
            begin
                report_mismatch($sformatf("raw_length got %0d want %0d",
                                          got_len, want.raw_length));
            end
            if (got_chars !== want.char_total)
            begin
                report_mismatch($sformatf("char_total got %0d want %0d",
                                          got_chars, want.char_total));
            end
            if (got_pad !== '0)
            begin
                report_mismatch($sformatf("padding bits got 0x%0h", got_pad));
            end
        end
        result_index++;
    endtask

    // Results are checked before the byte of the same edge is scanned; a
    // byte never yields its result at the edge it is transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            verdict_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
            end
        end
        pending_total = verdict_q.size();
    end

endmodule

### tb/tb_shift_jis_string_checker_top.sv
// ----------------------------------------------------------------------------
// tb_shift_jis_string_checker_top
// Drives byte buffers into the Shift-JIS string checker and gives the verdict.
// A directed set covers the byte class boundaries and the terminator and
// end-of-buffer corner cases; a random set mixes well-formed strings, broken
// strings and raw noise under random idling on both streams, with one long
// result hold-off. Checking lives in a separate checker module.
// ----------------------------------------------------------------------------
module tb_shift_jis_string_checker_top;
    import sjis_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    int         mismatches;
    int         results_due;
    bit         quiet = 1'b0;
    bit         long_hold_wanted = 1'b0;
    int         string_bytes = 0;
    logic [7:0] pend_bytes[$];

    always #5 clk = ~clk;

    shift_jis_string_checker_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    shift_jis_string_checker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // Offers one byte, with an occasional idle burst first, and returns at
    // the falling edge after its transfer.
    task automatic offer_byte(input logic [7:0] b, input logic eob);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            s_tlast  = 1'($urandom);
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eob;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Sends the pending buffer with tlast on its final byte.
    task automatic send_pending();
        for (int i = 0; i < pend_bytes.size(); i++)
        begin
            offer_byte(pend_bytes[i], i == pend_bytes.size() - 1);
        end
        string_bytes += pend_bytes.size();
        pend_bytes.delete();
    endtask

    function automatic logic [7:0] pick_single();
        case ($urandom_range(0, 9))
            0:       return BYTE_LF;
            1:       return BYTE_CR;
            2, 3, 4, 5, 6: return 8'($urandom_range(8'h20, 8'h7F));
            default: return 8'($urandom_range(8'hA1, 8'hDF));
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_single();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(8'h01, 8'h09));
            1:       return 8'($urandom_range(8'h0E, 8'h1F));
            2:       return 8'h80;
            3:       return 8'hA0;
            4:       return 8'($urandom_range(8'hF0, 8'hFF));
            default: return 8'($urandom_range(8'h0B, 8'h0C));
        endcase
    endfunction

    function automatic logic [7:0] pick_lead();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                    : 8'($urandom_range(8'hE0, 8'hEF));
    endfunction

    // Leads 0x89-0x97 and 0xE0-0xE9 accept any trail in range.
    task automatic add_good_pair();
        logic [7:0] trail;
        trail = 8'($urandom_range(8'h40, 8'hFC));
        if (trail == TRAIL_GAP)
        begin
            trail = 8'h80;
        end
        pend_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h89, 8'h97))
                                                  : 8'($urandom_range(8'hE0, 8'hE9)));
        pend_bytes.push_back(trail);
    endtask

    // Appends characters: mostly valid, with some arbitrary pairs that may
    // land on a bad trail or an excluded code.
    task automatic add_chars(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                pend_bytes.push_back(pick_single());
            end
            else if (pick < 88)
            begin
                add_good_pair();
            end
            else
            begin
                pend_bytes.push_back(pick_lead());
                pend_bytes.push_back(8'($urandom));
            end
        end
    endtask

    task automatic add_junk(input int max_n);
        repeat ($urandom_range(0, max_n))
        begin
            pend_bytes.push_back(8'($urandom));
        end
    endtask

    // Result side: random stall bursts, and one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_wanted)
            begin
                m_tready = 1'b0;
                repeat (300) @(negedge clk);
                long_hold_wanted = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // Run limit.
    initial
    begin
        #20000000;
        $display("shift_jis_string_checker_top test failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int kind;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty string, minimal string, single-byte class edges.
        pend_bytes = '{BYTE_NUL};
        send_pending();
        pend_bytes = '{8'h41, BYTE_NUL};
        send_pending();
        pend_bytes = '{BYTE_LF, BYTE_CR, ASCII_LO, ASCII_HI, KANA_LO, KANA_HI, BYTE_NUL};
        send_pending();
        // Lead range edges with valid trails.
        pend_bytes = '{LEAD1_LO, TRAIL_LO, LEAD2_LO, TRAIL_LO, LEAD1_HI, 8'hFC, BYTE_NUL};
        send_pending();
        // Top lead falls in an excluded range.
        pend_bytes = '{LEAD2_HI, TRAIL_LO};
        send_pending();
        // Lead on the final byte, then a terminator taken as a trail.
        pend_bytes = '{LEAD1_LO};
        send_pending();
        pend_bytes = '{8'h89, BYTE_NUL};
        send_pending();
        // No terminator; then an invalid byte followed by ignored bytes.
        pend_bytes = '{8'h42};
        send_pending();
        pend_bytes = '{8'h80, 8'hFF, BYTE_NUL};
        send_pending();

        // Random buffers; the long hold-off falls on the first ones.
        long_hold_wanted = 1'b1;
        while (string_bytes < 1200)
        begin
            if (string_bytes >= 1050)
            begin
                quiet = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                // Mostly well-formed string, sometimes empty, with up to three trailing bytes.
                add_chars(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10));
                pend_bytes.push_back(BYTE_NUL);
                add_junk(3);
            end
            else if (kind < 82)
            begin
                // Likely broken string: a chosen ending, then up to two random bytes.
                add_chars($urandom_range(0, 6));
                case ($urandom_range(0, 3))
                    0: pend_bytes.push_back(pick_lead());
                    1:
                    begin
                        if (pend_bytes.size() == 0)
                        begin
                            pend_bytes.push_back(pick_single());
                        end
                    end
                    2: pend_bytes.push_back(pick_bad_single());
                    default:
                    begin
                        pend_bytes.push_back(pick_lead());
                        pend_bytes.push_back(BYTE_NUL);
                    end
                endcase
                add_junk(2);
            end
            else
            begin
                // Raw noise.
                repeat ($urandom_range(1, 8)) pend_bytes.push_back(8'($urandom));
            end
            send_pending();
        end
        s_tvalid = 1'b0;

        // Drain and let any stray result show up.
        while (results_due != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("shift_jis_string_checker_top test passed");
        end
        else
        begin
            $display("shift_jis_string_checker_top test failed");
        end
        $finish;
    end

endmodule
